// ===== hw/rtl/scfp_pkg.sv =====
// Shared types and constants of the serial command frame parser.
package scfp_pkg;

  typedef enum logic [4:0] {
    PH_START    = 5'd0,
    PH_LPFX     = 5'd1,
    PH_GPFX     = 5'd2,
    PH_GCMD     = 5'd3,
    PH_OPEN_M   = 5'd4,
    PH_CLOSE_M  = 5'd5,
    PH_POS_M    = 5'd6,
    PH_OPEN_OK  = 5'd7,
    PH_CLOSE_OK = 5'd8,
    PH_PWS      = 5'd9,
    PH_PSIGN    = 5'd10,
    PH_PDIG     = 5'd11,
    PH_PDONE    = 5'd12,
    PH_LWS      = 5'd13,
    PH_LSIGN    = 5'd14,
    PH_LINT     = 5'd15,
    PH_LFRAC    = 5'd16,
    PH_LDONE    = 5'd17,
    PH_FAIL     = 5'd18
  } phase_e;

  typedef enum logic [2:0] {
    CMD_UP     = 3'd0,
    CMD_DOWN   = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_HEIGHT = 3'd3,
    CMD_OPEN   = 3'd4,
    CMD_CLOSE  = 3'd5,
    CMD_POS    = 3'd6
  } cmd_kind_e;

  localparam logic [7:0] ByteUp    = 8'h01;
  localparam logic [7:0] ByteDown  = 8'h02;
  localparam logic [7:0] ByteStop  = 8'h00;
  localparam logic [7:0] ByteStart = 8'h24;
  localparam logic [7:0] ByteEnd   = 8'h23;
  localparam logic [7:0] ByteColon = 8'h3A;
  localparam logic [7:0] BytePlus  = 8'h2B;
  localparam logic [7:0] ByteMinus = 8'h2D;
  localparam logic [7:0] ByteDot   = 8'h2E;
  localparam logic [31:0] HeightMax = 32'h7FFF_FFFF;

  // One classified beat handed from the front part to the back part.
  typedef enum logic [1:0] {
    ACT_DIRECT = 2'd0, // immediate command outside a frame
    ACT_OPEN   = 2'd1, // '$': start or restart a frame
    ACT_CLOSE  = 2'd2, // '#': decode and close
    ACT_BODY   = 2'd3  // body byte
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] data;
  } work_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] height;
    logic [15:0] pos;
  } result_t;

  function automatic logic [7:0] key_lifter(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0: c = 8'h4C; 3'd1: c = 8'h49; 3'd2: c = 8'h46; 3'd3: c = 8'h54;
      3'd4: c = 8'h45; 3'd5: c = 8'h52; 3'd6: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] key_gripper(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0: c = 8'h47; 3'd1: c = 8'h52; 3'd2: c = 8'h49; 3'd3: c = 8'h50;
      3'd4: c = 8'h50; 3'd5: c = 8'h45; 3'd6: c = 8'h52; 3'd7: c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Gripper sub-keyword letters; index 0 is matched in the command phase.
  function automatic logic [7:0] key_sub(input phase_e ph, input logic [2:0] k);
    logic [7:0] c;
    c = 8'h00;
    if (ph == PH_OPEN_M) begin
      unique case (k)
        3'd0: c = 8'h4F; 3'd1: c = 8'h50; 3'd2: c = 8'h45; 3'd3: c = 8'h4E;
        default: c = 8'h00;
      endcase
    end else if (ph == PH_CLOSE_M) begin
      unique case (k)
        3'd0: c = 8'h43; 3'd1: c = 8'h4C; 3'd2: c = 8'h4F; 3'd3: c = 8'h53;
        3'd4: c = 8'h45;
        default: c = 8'h00;
      endcase
    end else begin
      unique case (k)
        3'd0: c = 8'h50; 3'd1: c = 8'h4F; 3'd2: c = 8'h53;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/serial_command_frame_parser_unit.sv =====
// Top level of the serial command frame parser.
//
// Usage: one received serial byte enters per beat on the s_axis channel
// (tdata = rx_byte). Decoded commands leave on the m_axis channel; tdata
// carries cmd_kind, height_milli and grip_position. Outside a frame the
// bytes 0x01, 0x02 and 0x00 give up, down and stop immediately. A frame
// runs from '$' to '#' and yields at most one command at its '#'.
// A beat that causes a command is registered first in the front-to-back queue,
// then the command is registered in the output register.
// Throughput: one byte per cycle, sustained while m_axis_tready stays high;
// the body matcher's state registers are updated once per byte, and height
// digits take one multiply-by-ten and add per byte.
// Reset clears frame state, the queue and the output valid flag; no result
// is pending afterwards. When the receiver stalls with a command waiting,
// the output register holds and the back part takes no further beats,
// whether they cause a result or not; the two-entry queue absorbs up to
// two more bytes and then s_axis_tready drops until the command leaves.
module serial_command_frame_parser_unit
  import scfp_pkg::*;
#(
  parameter int CMD_BUF_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [2:0] cmd_kind, [34:3] height_milli,
                                      // [50:35] grip_position, [55:51] zero
);

  logic    fq_wr_valid, fq_wr_ready, fq_rd_valid, fq_rd_ready;
  work_t   fq_wr_work, fq_rd_work;
  result_t res;

  scfp_front #(.CmdBufSize(CMD_BUF_SIZE)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .wr_valid_o (fq_wr_valid),
    .wr_ready_i (fq_wr_ready),
    .wr_work_o  (fq_wr_work)
  );

  scfp_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (fq_wr_valid),
    .wr_ready_o (fq_wr_ready),
    .wr_work_i  (fq_wr_work),
    .rd_valid_o (fq_rd_valid),
    .rd_ready_i (fq_rd_ready),
    .rd_work_o  (fq_rd_work)
  );

  scfp_back u_back (
    .clk_i, .rst_ni,
    .rd_valid_i  (fq_rd_valid),
    .rd_ready_o  (fq_rd_ready),
    .rd_work_i   (fq_rd_work),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'd0, res.pos, res.height, res.kind};

endmodule

// ===== hw/rtl/scfp_front.sv =====
// Front part: takes received bytes, tracks frame state and classifies each beat.
module scfp_front
  import scfp_pkg::*;
#(
  parameter int CmdBufSize = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       wr_valid_o,
  input  logic       wr_ready_i,
  output work_t      wr_work_o
);

  localparam int LenW = $clog2(CmdBufSize);

  logic            in_frame_q, in_frame_d;
  logic [LenW-1:0] len_q, len_d;
  logic            fire;

  assign in_ready_o = wr_ready_i;
  assign fire       = in_valid_i && wr_ready_i;

  always_comb begin
    in_frame_d        = in_frame_q;
    len_d             = len_q;
    wr_valid_o        = 1'b0;
    wr_work_o.action  = ACT_BODY;
    wr_work_o.data    = in_byte_i;
    if (!in_frame_q && in_byte_i <= ByteDown) begin
      wr_valid_o       = in_valid_i;
      wr_work_o.action = ACT_DIRECT;
    end else if (in_byte_i == ByteStart) begin
      wr_valid_o       = in_valid_i;
      wr_work_o.action = ACT_OPEN;
      in_frame_d       = 1'b1;
      len_d            = '0;
    end else if (in_frame_q && in_byte_i == ByteEnd) begin
      wr_valid_o       = in_valid_i;
      wr_work_o.action = ACT_CLOSE;
      in_frame_d       = 1'b0;
    end else if (in_frame_q) begin
      if (len_q < LenW'(CmdBufSize - 1)) begin
        wr_valid_o = in_valid_i;
        len_d      = len_q + 1'b1;
      end else begin
        // Overlong body: the frame is dropped without a result.
        in_frame_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      len_q      <= '0;
    end else if (fire) begin
      in_frame_q <= in_frame_d;
      len_q      <= len_d;
    end
  end

endmodule

// ===== hw/rtl/scfp_fifo.sv =====
// Short queue between the front and back parts.
module scfp_fifo
  import scfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  work_t wr_work_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output work_t rd_work_o
);

  work_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_work_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/scfp_back.sv =====
// Back part: matches body text on the fly and issues decoded commands.
module scfp_back
  import scfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    rd_valid_i,
  output logic    rd_ready_o,
  input  work_t   rd_work_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  phase_e      ph_q, ph_d;
  logic [3:0]  idx_q, idx_d;       // text position, saturates at 15
  logic        ended_q, ended_d;
  logic        neg_q, neg_d;
  logic [31:0] hacc_q, hacc_d;
  logic [1:0]  frac_q, frac_d;
  logic [15:0] pacc_q, pacc_d;
  logic        pp_q, pp_d;
  logic        res_valid_q;
  result_t     res_q, res_d;
  logic        emit;
  logic        take;

  logic [7:0]  b;
  logic [3:0]  dig;
  logic        is_dig, is_blank;
  logic [2:0]  k;
  logic [2:0]  kwlen;
  logic [35:0] hmul;
  logic [35:0] hsum;
  phase_e      ph_set;   // phase after the text is settled

  assign rd_ready_o  = !res_valid_q || res_ready_i;
  assign take        = rd_valid_i && rd_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign b        = rd_work_i.data;
  assign dig      = b[3:0];
  assign is_dig   = b >= 8'h30 && b <= 8'h39;
  assign is_blank = b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  assign k        = 3'(idx_q - 4'd8);
  assign kwlen    = (ph_q == PH_OPEN_M) ? 3'd4 : ((ph_q == PH_CLOSE_M) ? 3'd5 : 3'd3);

  always_comb begin
    unique case (ph_q)
      PH_START, PH_LPFX, PH_GPFX, PH_GCMD, PH_POS_M: ph_set = PH_FAIL;
      PH_OPEN_M:  ph_set = (idx_q == 4'd12) ? PH_OPEN_OK : PH_FAIL;
      PH_CLOSE_M: ph_set = (idx_q == 4'd13) ? PH_CLOSE_OK : PH_FAIL;
      default:    ph_set = ph_q;
    endcase
  end

  // Height digit arithmetic: x10 plus digit scaled, or fraction add.
  always_comb begin
    if (ph_q == PH_LFRAC) begin
      hmul = {4'd0, hacc_q};
      unique case (frac_q)
        2'd0:    hsum = hmul + 36'(dig) * 36'd100;
        2'd1:    hsum = hmul + 36'(dig) * 36'd10;
        default: hsum = hmul + 36'(dig);
      endcase
    end else begin
      hmul = {1'b0, hacc_q, 3'b0} + {3'b0, hacc_q, 1'b0};
      hsum = hmul + 36'(dig) * 36'd1000;
    end
  end

  always_comb begin
    ph_d    = ph_q;
    idx_d   = idx_q;
    ended_d = ended_q;
    neg_d   = neg_q;
    hacc_d  = hacc_q;
    frac_d  = frac_q;
    pacc_d  = pacc_q;
    pp_d    = pp_q;
    emit    = 1'b0;
    res_d.kind   = CMD_STOP;
    res_d.height = '0;
    res_d.pos    = '0;
    unique case (rd_work_i.action)
      ACT_DIRECT: begin
        emit = 1'b1;
        res_d.kind = (b == ByteUp) ? CMD_UP : ((b == ByteDown) ? CMD_DOWN : CMD_STOP);
      end
      ACT_OPEN, ACT_CLOSE: begin
        ph_d = PH_START; idx_d = '0; ended_d = 1'b0; neg_d = 1'b0;
        hacc_d = '0; frac_d = '0; pacc_d = '0; pp_d = 1'b0;
        if (rd_work_i.action == ACT_CLOSE) begin
          priority if (ph_set == PH_OPEN_OK) begin
            emit = 1'b1; res_d.kind = CMD_OPEN;
          end else if (ph_set == PH_CLOSE_OK) begin
            emit = 1'b1; res_d.kind = CMD_CLOSE;
          end else if (ph_set >= PH_PWS && ph_set <= PH_PDONE && pp_q) begin
            emit = 1'b1; res_d.kind = CMD_POS;
            res_d.pos = neg_q ? 16'(-pacc_q) : pacc_q;
          end else if (ph_set >= PH_LWS && ph_set <= PH_LDONE) begin
            emit = 1'b1; res_d.kind = CMD_HEIGHT;
            res_d.height = neg_q ? -hacc_q : hacc_q;
          end
        end
      end
      default: begin
        if (idx_q != 4'd15) idx_d = idx_q + 1'b1;
        if (!ended_q) begin
          if (b == ByteStop) begin
            ph_d = ph_set; ended_d = 1'b1;
          end else begin
            unique case (ph_q)
              PH_START: ph_d = (b == 8'h4C) ? PH_LPFX : ((b == 8'h47) ? PH_GPFX : PH_FAIL);
              PH_LPFX:
                if (idx_q < 4'd7 && b == key_lifter(idx_q[2:0]))
                  ph_d = (idx_q == 4'd6) ? PH_LWS : PH_LPFX;
                else ph_d = PH_FAIL;
              PH_GPFX:
                if (idx_q < 4'd8 && b == key_gripper(idx_q[2:0]))
                  ph_d = (idx_q == 4'd7) ? PH_GCMD : PH_GPFX;
                else ph_d = PH_FAIL;
              PH_GCMD:
                ph_d = (b == 8'h4F) ? PH_OPEN_M :
                       ((b == 8'h43) ? PH_CLOSE_M : ((b == 8'h50) ? PH_POS_M : PH_FAIL));
              PH_OPEN_M, PH_CLOSE_M, PH_POS_M: begin
                if (k < kwlen) begin
                  if (b != key_sub(ph_q, k)) ph_d = PH_FAIL;
                end else if (k == kwlen && b == ByteColon) begin
                  if (ph_q == PH_OPEN_M) ph_d = PH_OPEN_OK;
                  else if (ph_q == PH_CLOSE_M) ph_d = PH_CLOSE_OK;
                  else begin pp_d = 1'b1; ph_d = PH_PWS; end
                end else ph_d = PH_FAIL;
              end
              PH_PWS, PH_PSIGN, PH_PDIG: begin
                if (ph_q == PH_PWS && is_blank) begin
                end else if (ph_q == PH_PWS && (b == BytePlus || b == ByteMinus)) begin
                  neg_d = b == ByteMinus; ph_d = PH_PSIGN;
                end else if (is_dig) begin
                  pacc_d = 16'({pacc_q, 3'b0} + {2'b0, pacc_q, 1'b0} + 19'(dig));
                  ph_d = PH_PDIG;
                end else ph_d = PH_PDONE;
              end
              PH_LWS, PH_LSIGN, PH_LINT: begin
                if (ph_q == PH_LWS && is_blank) begin
                end else if (ph_q == PH_LWS && (b == BytePlus || b == ByteMinus)) begin
                  neg_d = b == ByteMinus; ph_d = PH_LSIGN;
                end else if (is_dig) begin
                  hacc_d = (hsum > 36'(HeightMax)) ? HeightMax : hsum[31:0];
                  ph_d = PH_LINT;
                end else if (b == ByteDot) ph_d = PH_LFRAC;
                else ph_d = PH_LDONE;
              end
              PH_LFRAC: begin
                if (is_dig) begin
                  if (frac_q != 2'd3) begin
                    hacc_d = (hsum > 36'(HeightMax)) ? HeightMax : hsum[31:0];
                    frac_d = frac_q + 1'b1;
                  end
                end else ph_d = PH_LDONE;
              end
              PH_OPEN_OK, PH_CLOSE_OK, PH_PDONE, PH_LDONE, PH_FAIL: ;
              default: ph_d = PH_FAIL;
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_START; idx_q <= '0; ended_q <= 1'b0; neg_q <= 1'b0;
      hacc_q <= '0; frac_q <= '0; pacc_q <= '0; pp_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        ph_q <= ph_d; idx_q <= idx_d; ended_q <= ended_d; neg_q <= neg_d;
        hacc_q <= hacc_d; frac_q <= frac_d; pacc_q <= pacc_d; pp_q <= pp_d;
      end
      if (take) res_valid_q <= emit;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) res_q <= res_d;
  end

endmodule

// ===== hw/rtl/scfp_checker.sv =====
// Port-level checker for the serial command frame parser, bound to the top.
module scfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
    else $error("illegal command kind");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:51] == 5'd0)
    else $error("padding not zero");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'd3 |-> m_axis_tdata[34:3] == 32'd0)
    else $error("height set for a non-height command");

endmodule

bind serial_command_frame_parser_unit scfp_checker u_scfp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
